// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/bni_pkg.sv -----
// Types and constants shared by the batch normalization datapath.
`default_nettype none

package bni_pkg;

	localparam int RAD_W  = 25;
	localparam int ROOT_W = 13;
	localparam int MAG_W  = 32;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef struct packed {
		logic [7:0]         ch;
		logic signed [15:0] bias;
		logic               neg;
		logic [MAG_W-1:0]   mag;
	} sq_side_t;

	typedef struct packed {
		logic [7:0]         ch;
		logic signed [15:0] bias;
		logic               neg;
		logic               zero;
	} dv_side_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         ch;
		logic signed [15:0] value;
	} out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bni_isqrt.sv -----
// Pipelined integer square root, one root bit resolved per stage.
`default_nettype none

module bni_isqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [bni_pkg::RAD_W-1:0]  in_rad,
	input  wire bni_pkg::sq_side_t          in_side,
	output logic                            out_valid,
	output logic [bni_pkg::ROOT_W-1:0]      out_root,
	output bni_pkg::sq_side_t               out_side
);

	localparam int N  = bni_pkg::ROOT_W;
	localparam int TW = bni_pkg::RAD_W + 3;

	logic [TW-1:0]     rem_q  [N];
	logic [N-1:0]      root_q [N];
	logic              vld_q  [N];
	bni_pkg::sq_side_t side_q [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int B = N - 1 - k;
		logic [TW-1:0]     rem_i;
		logic [N-1:0]      root_i;
		logic              vld_i;
		bni_pkg::sq_side_t side_i;
		logic [TW-1:0]     trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_i  = TW'(in_rad);
			assign root_i = '0;
			assign vld_i  = in_valid;
			assign side_i = in_side;
		end else begin : g_next
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign vld_i  = vld_q[k-1];
			assign side_i = side_q[k-1];
		end

		// Candidate (R + 2^B)^2 - R^2 against what is left of the radicand.
		assign trial = (TW'(root_i) << (B + 1)) + (TW'(1) << (2 * B));
		assign ge    = rem_i >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? rem_i - trial : rem_i;
				root_q[k] <= ge ? (root_i | (N'(1) << B)) : root_i;
				side_q[k] <= side_i;
			end
		end
	end

	assign out_valid = vld_q[N-1];
	assign out_root  = root_q[N-1];
	assign out_side  = side_q[N-1];

endmodule

`default_nettype wire

// ----- hw/rtl/bni_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, unsigned.
`default_nettype none

module bni_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire logic [bni_pkg::MAG_W-1:0]  in_mag,
	input  wire logic [bni_pkg::ROOT_W-1:0] in_div,
	input  wire bni_pkg::dv_side_t          in_side,
	output logic                            out_valid,
	output logic [bni_pkg::MAG_W-1:0]       out_quot,
	output bni_pkg::dv_side_t               out_side
);

	localparam int N  = bni_pkg::MAG_W;
	localparam int DW = bni_pkg::ROOT_W;

	logic [DW-1:0]     r_q    [N];
	logic [N-1:0]      nq_q   [N];
	logic [DW-1:0]     d_q    [N];
	logic              vld_q  [N];
	bni_pkg::dv_side_t side_q [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [DW-1:0]     r_i;
		logic [N-1:0]      nq_i;
		logic [DW-1:0]     d_i;
		logic              vld_i;
		bni_pkg::dv_side_t side_i;
		logic [DW:0]       t;
		logic [DW:0]       t_sub;
		logic              ge;

		if (k == 0) begin : g_first
			assign r_i    = '0;
			assign nq_i   = in_mag;
			assign d_i    = in_div;
			assign vld_i  = in_valid;
			assign side_i = in_side;
		end else begin : g_next
			assign r_i    = r_q[k-1];
			assign nq_i   = nq_q[k-1];
			assign d_i    = d_q[k-1];
			assign vld_i  = vld_q[k-1];
			assign side_i = side_q[k-1];
		end

		// Shift the next dividend bit into the partial remainder and try to subtract.
		assign t     = {r_i, nq_i[N-1]};
		assign t_sub = t - {1'b0, d_i};
		assign ge    = t >= {1'b0, d_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k]    <= ge ? t_sub[DW-1:0] : t[DW-1:0];
				nq_q[k]   <= {nq_i[N-2:0], ge};
				d_q[k]    <= d_i;
				side_q[k] <= side_i;
			end
		end
	end

	assign out_valid = vld_q[N-1];
	assign out_quot  = nq_q[N-1];
	assign out_side  = side_q[N-1];

endmodule

`default_nettype wire

// ----- hw/rtl/batch_norm_inference.sv -----
// Top level of the per-channel batch normalization block for inference.
`default_nettype none

// Batch normalization in signed Q8.8. A transfer with s_tuser low loads one channel's
// mean, variance, weight and bias into the parameter memory and yields nothing; a
// transfer with s_tuser high normalizes one sample as
// weight*(value-mean)/floor_sqrt((variance+epsilon)*256)+bias, with the quotient
// truncated toward zero and the sum saturated to 16 bits. A channel at or beyond
// CHANNELS is ignored. The block takes one transfer every cycle while it is not
// stalled. A sample passes through the parameter memory read, the subtract, the
// multiply, the pipelined square root, the pipelined divider (one quotient bit per
// stage) and the registered bias add and saturation. Results enter a two-entry
// output buffer; the whole pipeline stalls only while that buffer is full and a
// finished result waits behind it. Loads write the memory at the cycle they are
// taken and samples read it at the cycle they are taken, so a sample always sees
// every load taken before it. A channel that was never loaded returns undefined
// values. The epsilon register resets to 1 and must only be written while no
// sample is in flight.
module batch_norm_inference #(
	parameter int CHANNELS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// channel[7:0], sample_value[23:8], mean_in[39:24], variance_in[55:40],
	// scale_in[71:56], shift_in[87:72]
	input  wire logic [87:0] s_tdata,
	// kind[0]
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// result_value[15:0], channel_out[23:16], status[25:24], zeros above
	output logic [31:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Input fields.
	logic [7:0]         ch_in;
	logic signed [15:0] value_in;
	logic [63:0]        params_in;
	logic [AW-1:0]      addr;
	logic               in_range;
	logic               acc;
	logic               en;

	assign ch_in     = s_tdata[7:0];
	assign value_in  = s_tdata[23:8];
	assign params_in = s_tdata[87:24];
	assign addr      = AW'(ch_in);
	assign in_range  = 32'(ch_in) < 32'(CHANNELS);

	// The pipeline advances unless a finished result waits while the buffer is full.
	logic [1:0] cnt_q;
	logic       valid_s4;

	assign en       = !(valid_s4 && (cnt_q == 2'd2));
	assign s_tready = en;
	assign acc      = s_tvalid && en;

	// Epsilon register; always ready.
	logic [15:0] eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= 16'd1;
		end else if (cfg_valid) begin
			eps_q <= cfg_data;
		end
	end

	// Parameter memory: {shift, scale, variance, mean} per channel.
	logic [63:0] param_mem [CHANNELS];
	logic [63:0] rd_s1;

	always_ff @(posedge clk) begin
		if (acc && (s_tuser == bni_pkg::KIND_LOAD) && in_range) begin
			param_mem[addr] <= params_in;
		end
		if (en) begin
			rd_s1 <= param_mem[addr];
		end
	end

	// Stage 1: sample data alongside the memory read.
	logic               valid_s1;
	logic signed [15:0] value_s1;
	logic [7:0]         ch_s1;

	// Stage 2: difference and variance sum.
	logic               valid_s2;
	logic signed [16:0] diff_s2;
	logic [16:0]        vsum_s2;
	logic signed [15:0] scale_s2;
	logic signed [15:0] bias_s2;
	logic [7:0]         ch_s2;

	// Stage 3: product and radicand.
	logic               valid_s3;
	logic signed [32:0] prod_s3;
	logic [bni_pkg::RAD_W-1:0] rad_s3;
	logic signed [15:0] bias_s3;
	logic [7:0]         ch_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= acc && (s_tuser == bni_pkg::KIND_SAMPLE) && in_range;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s1 <= value_in;
			ch_s1    <= ch_in;

			diff_s2  <= 17'(value_s1) - 17'(signed'(rd_s1[15:0]));
			vsum_s2  <= 17'(rd_s1[31:16]) + 17'(eps_q);
			scale_s2 <= rd_s1[47:32];
			bias_s2  <= rd_s1[63:48];
			ch_s2    <= ch_s1;

			prod_s3  <= 33'(scale_s2) * 33'(diff_s2);
			rad_s3   <= {vsum_s2, 8'd0};
			bias_s3  <= bias_s2;
			ch_s3    <= ch_s2;
		end
	end

	// Square root of the radicand, with the product magnitude riding along.
	logic signed [32:0] prod_neg;
	bni_pkg::sq_side_t  sq_in;
	bni_pkg::sq_side_t  sq_out;
	logic               sq_valid;
	logic [bni_pkg::ROOT_W-1:0] root;

	assign prod_neg   = -prod_s3;
	assign sq_in.ch   = ch_s3;
	assign sq_in.bias = bias_s3;
	assign sq_in.neg  = prod_s3[32];
	assign sq_in.mag  = prod_s3[32] ? prod_neg[31:0] : prod_s3[31:0];

	bni_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_rad    (rad_s3),
		.in_side   (sq_in),
		.out_valid (sq_valid),
		.out_root  (root),
		.out_side  (sq_out)
	);

	// Magnitude division by the root.
	bni_pkg::dv_side_t dv_in;
	bni_pkg::dv_side_t dv_out;
	logic              dv_valid;
	logic [bni_pkg::MAG_W-1:0] quot;

	assign dv_in.ch   = sq_out.ch;
	assign dv_in.bias = sq_out.bias;
	assign dv_in.neg  = sq_out.neg;
	assign dv_in.zero = (root == '0);

	bni_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_mag    (sq_out.mag),
		.in_div    (root),
		.in_side   (dv_in),
		.out_valid (dv_valid),
		.out_quot  (quot),
		.out_side  (dv_out)
	);

	// Stage 4: restore the sign, add the bias and saturate.
	logic signed [33:0] q_signed;
	logic signed [33:0] sum;
	bni_pkg::out_item_t res_n;
	bni_pkg::out_item_t res_s4;

	assign q_signed = dv_out.neg ? -34'(quot) : 34'(quot);
	assign sum      = q_signed + 34'(dv_out.bias);

	always_comb begin
		res_n.ch = dv_out.ch;
		if (dv_out.zero) begin
			res_n.value  = dv_out.bias;
			res_n.status = bni_pkg::ST_ZERO;
		end else if (sum > 34'sd32767) begin
			res_n.value  = 16'sh7fff;
			res_n.status = bni_pkg::ST_SAT;
		end else if (sum < -34'sd32768) begin
			res_n.value  = 16'sh8000;
			res_n.status = bni_pkg::ST_SAT;
		end else begin
			res_n.value  = sum[15:0];
			res_n.status = bni_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4 <= res_n;
		end
	end

	// Two-entry output buffer; entry 0 is the head.
	bni_pkg::out_item_t fifo_q [2];
	logic push;
	logic pop;
	logic [1:0] cnt_left;

	assign push     = en && valid_s4;
	assign pop      = m_tvalid && m_tready;
	assign cnt_left = pop ? cnt_q - 2'd1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_left + {1'b0, push};
		end
	end

	// A new result lands in the first slot left free after this cycle's pop.
	always_ff @(posedge clk) begin
		if (push && (cnt_left == 2'd0)) begin
			fifo_q[0] <= res_s4;
		end else if (pop) begin
			fifo_q[0] <= fifo_q[1];
		end
		if (push && (cnt_left == 2'd1)) begin
			fifo_q[1] <= res_s4;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {6'd0, fifo_q[0]};

endmodule

`default_nettype wire

// ----- hw/rtl/bni_checker.sv -----
// Port-level checker for the batch normalization block, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module bni_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic        cfg_ready
);

	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
	`ASSERT_SAME(a_sat_rail, m_tvalid && (m_tdata[25:24] == bni_pkg::ST_SAT), (m_tdata[15:0] == 16'h7fff) || (m_tdata[15:0] == 16'h8000), "saturated result not at a rail")
	`ASSERT_SAME(a_status_code, m_tvalid, (m_tdata[25:24] != 2'd3) && (m_tdata[31:26] == 6'd0) && cfg_ready, "bad status or padding")

endmodule

bind batch_norm_inference bni_checker u_bni_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the batch normalization inference block.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Expected result of one sample transfer.
	typedef struct {
		logic signed [15:0] value;
		logic [7:0]         ch;
		logic [1:0]         status;
	} norm_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// channel[7:0], sample_value[23:8], mean_in[39:24], variance_in[55:40],
	// scale_in[71:56], shift_in[87:72]
	logic [87:0] s_tdata;
	// kind[0]
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// result_value[15:0], channel_out[23:16], status[25:24], zeros above
	logic [31:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// Shadow copy of the parameter memory and of the epsilon register.
	logic [15:0] mean_mem [256];
	logic [15:0] var_mem [256];
	logic [15:0] weight_mem [256];
	logic [15:0] bias_mem [256];
	bit          loaded [256];
	logic [15:0] eps_reg;

	norm_result_t pending_results [$];
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          failed;

	batch_norm_inference #(.CHANNELS(256)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Integer square root by the digit-by-digit method.
	function automatic longint isqrt(longint v);
		longint root;
		longint bitv;
		root = 0;
		bitv = longint'(1) << 30;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Normalizes one sample against the shadow parameters of its channel.
	function automatic norm_result_t normalize(logic [7:0] ch, logic signed [15:0] x);
		norm_result_t r;
		longint mean, wgt, bias, sd, prod, sum;
		mean = longint'($signed(mean_mem[ch]));
		wgt = longint'($signed(weight_mem[ch]));
		bias = longint'($signed(bias_mem[ch]));
		sd = isqrt((longint'(var_mem[ch]) + longint'(eps_reg)) * 256);
		r.ch = ch;
		r.status = bni_pkg::ST_OK;
		if (sd == 0) begin
			sum = bias;
			r.status = bni_pkg::ST_ZERO;
		end else begin
			prod = wgt * (longint'(x) - mean);
			// SystemVerilog division truncates toward zero, as required.
			sum = prod / sd + bias;
			if (sum > 32767) begin
				sum = 32767;
				r.status = bni_pkg::ST_SAT;
			end else if (sum < -32768) begin
				sum = -32768;
				r.status = bni_pkg::ST_SAT;
			end
		end
		r.value = sum[15:0];
		return r;
	endfunction

	// Drives one transfer and updates the prediction when it is accepted.
	task automatic send_item(logic kind, logic [7:0] ch, logic [15:0] x, logic [15:0] mean,
			logic [15:0] vr, logic [15:0] wgt, logic [15:0] bias);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {bias, wgt, vr, mean, x, ch};
		do @(posedge clk); while (!s_tready);
		if (kind == bni_pkg::KIND_LOAD) begin
			mean_mem[ch] = mean;
			var_mem[ch] = vr;
			weight_mem[ch] = wgt;
			bias_mem[ch] = bias;
			loaded[ch] = 1'b1;
		end else begin
			pending_results.push_back(normalize(ch, x));
		end
	endtask

	task automatic send_load(logic [7:0] ch, logic [15:0] mean, logic [15:0] vr,
			logic [15:0] wgt, logic [15:0] bias);
		send_item(bni_pkg::KIND_LOAD, ch, 16'($urandom), mean, vr, wgt, bias);
	endtask

	task automatic send_sample(logic [7:0] ch, logic [15:0] x);
		send_item(bni_pkg::KIND_SAMPLE, ch, x, 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	// Waits until every expected result has arrived, then lets the pipeline drain.
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_epsilon(logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		eps_reg = value;
		cfg_valid <= 1'b0;
	endtask

	// Extremes of every field, both kinds, saturation both ways, zero divisor.
	task automatic test_directed;
		send_load(8'd0, 16'h0000, 16'h0100, 16'h0100, 16'h0000);
		send_sample(8'd0, 16'h7FFF);
		send_sample(8'd0, 16'h8000);
		send_sample(8'd0, 16'h0000);
		send_load(8'd255, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF);
		send_sample(8'd255, 16'h7FFF);
		send_load(8'd1, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000);
		send_sample(8'd1, 16'h8000);
		send_load(8'd2, 16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF);
		send_sample(8'd2, 16'h7FFF);
		send_sample(8'd2, 16'hFFFF);
		send_sample(8'd255, 16'h8000);
		// Zero divisor: variance and epsilon both zero.
		write_epsilon(16'h0000);
		send_load(8'd3, 16'h1234, 16'h0000, 16'h7FFF, 16'hABCD);
		send_sample(8'd3, 16'h7FFF);
		send_sample(8'd0, 16'h0100);
		write_epsilon(16'hFFFF);
		send_sample(8'd2, 16'h8000);
		send_sample(8'd255, 16'h0001);
		write_epsilon(16'd1);
	endtask

	// Random loads and samples; samples only touch loaded channels.
	task automatic test_random(int count);
		logic [7:0] ch;
		for (int i = 0; i < count; i++) begin
			ch = 8'($urandom);
			if (!loaded[ch] || $urandom_range(4) == 0) begin
				send_load(ch, 16'($urandom), ($urandom_range(3) == 0) ?
					16'($urandom_range(3)) : 16'($urandom), 16'($urandom),
					16'($urandom));
			end else begin
				send_sample(ch, 16'($urandom));
			end
		end
	endtask

	// Checks each result transfer against the oldest expectation.
	always @(posedge clk) begin
		norm_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer %h", m_tdata);
				failed = 1'b1;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[15:0] !== exp_r.value) begin
					$error("result_value expected %h got %h", exp_r.value, m_tdata[15:0]);
					failed = 1'b1;
				end
				if (m_tdata[23:16] !== exp_r.ch) begin
					$error("channel_out expected %h got %h", exp_r.ch, m_tdata[23:16]);
					failed = 1'b1;
				end
				if (m_tdata[25:24] !== exp_r.status) begin
					$error("status expected %h got %h", exp_r.status, m_tdata[25:24]);
					failed = 1'b1;
				end
			end
		end
	end

	// Receiver backpressure, driven at the rising edge.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		failed = 1'b0;
		eps_reg = 16'd1;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (loaded[i]) loaded[i] = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b1;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(300);
		write_epsilon(16'($urandom));
		send_idle_pct = 52;
		test_random(280);
		write_epsilon(16'h0000);
		send_idle_pct = 0;
		recv_stall_pct = 52;
		test_random(280);
		write_epsilon(16'hFFFF);
		send_idle_pct = 27;
		recv_stall_pct = 27;
		test_random(270);
		drain();

		if (!failed) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/bni_pkg.sv
hw/rtl/bni_isqrt.sv
hw/rtl/bni_div.sv
hw/rtl/batch_norm_inference.sv
hw/rtl/bni_checker.sv
test/testbench.sv
